// ===== src/fdt_pkg.sv =====
`timescale 1ns / 1ps
// fdt_pkg: constants and the month table shared by the date/time converter
// no dependencies; imported by every module of the block

package fdt_pkg;

  // register stages inside each conversion path, output register not counted
  localparam int unsigned STAGES = 6;

  localparam logic [16:0] SECS_PER_DAY      = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR     = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN      = 6'd60;
  localparam logic [8:0]  DAYS_PER_YEAR     = 9'd365;
  localparam logic [31:0] SECS_1980         = 32'd315532800;
  localparam logic [15:0] DAYS_1970_TO_1980 = 16'd3652;
  localparam logic [3:0]  MONTH_FEB         = 4'd2;
  localparam logic [3:0]  MONTH_DEC         = 4'd12;
  localparam logic [8:0]  DOY_FEB29         = 9'd59;

  // reciprocals for exact division by a constant, value = floor(x * R >> shift)
  // x / 675 for x < 2^25, shift 35 (u / 86400 after dropping 7 low bits)
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  // x / 225 for x < 5400, shift 22 (seconds of day / 3600 after >> 4)
  localparam logic [14:0] HOUR_RECIP = 15'd18642;
  // x / 15 for x < 900, shift 14 (seconds of hour / 60 after >> 2)
  localparam logic [10:0] MIN_RECIP  = 11'd1093;
  // x / 365 for x < 2^16, shift 24
  localparam logic [15:0] YEAR_RECIP = 16'd45965;

  // days before each month in a common year, unused codes give zero
  function automatic logic [8:0] cum_days(input logic [3:0] idx);
    logic [8:0] res;
    case (idx)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd59;
      4'd3:    res = 9'd90;
      4'd4:    res = 9'd120;
      4'd5:    res = 9'd151;
      4'd6:    res = 9'd181;
      4'd7:    res = 9'd212;
      4'd8:    res = 9'd243;
      4'd9:    res = 9'd273;
      4'd10:   res = 9'd304;
      4'd11:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== src/fat_date_time_convert.sv =====
`timescale 1ns / 1ps
// fat_date_time_convert: top level, fat time/date pair <-> unix seconds
// depends on fdt_pkg, fdt_d2u and fdt_u2d
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid / in_stall | action, dos_time, dos_date, unix_seconds
//   output  | out_valid/out_stall | seconds_out, time_out, date_out
//
// one item per cycle while the output is not stalled; the pipeline depth is
// set by the chain of reciprocal multiplies in the unix-to-dos path.
// both directions are computed for every beat and the action bit picks one.
// reset clears the valid bit of every stage and of the output register.
// a stalled output freezes the whole pipeline, so nothing is lost or repeated.

module fat_date_time_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [15:0] dos_time,
  input  logic [15:0] dos_date,
  input  logic [31:0] unix_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [32:0] seconds_out,
  output logic [15:0] time_out,
  output logic [15:0] date_out
);
  import fdt_pkg::*;

  logic              adv;
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] act;
  logic [32:0]       d2u_secs;
  logic [15:0]       u2d_time;
  logic [15:0]       u2d_date;

  // advance everything unless the output beat is held
  assign in_stall = out_valid & out_stall;
  assign adv      = ~in_stall;

  fdt_d2u u_d2u (
    .clk      (clk),
    .en       (adv),
    .dos_time (dos_time),
    .dos_date (dos_date),
    .seconds  (d2u_secs)
  );

  fdt_u2d u_u2d (
    .clk          (clk),
    .en           (adv),
    .unix_seconds (unix_seconds),
    .time_out     (u2d_time),
    .date_out     (u2d_date)
  );

  // valid bits travelling with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[STAGES-2:0], in_valid};
      out_valid <= vld[STAGES-1];
    end
  end

  // direction bit and output register
  always_ff @(posedge clk) begin
    if (adv) begin
      act <= {act[STAGES-2:0], action};
      if (act[STAGES-1]) begin
        seconds_out <= '0;
        time_out    <= u2d_time;
        date_out    <= u2d_date;
      end else begin
        seconds_out <= d2u_secs;
        time_out    <= '0;
        date_out    <= '0;
      end
    end
  end

endmodule

// ===== src/fdt_d2u.sv =====
`timescale 1ns / 1ps
// fdt_d2u: packed dos time/date pair to unix seconds, fixed-latency datapath
// depends on fdt_pkg

module fdt_d2u (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] dos_time,
  input  logic [15:0] dos_date,
  output logic [32:0] seconds
);
  import fdt_pkg::*;

  logic [4:0]  sec2;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [4:0]  day;
  logic [3:0]  mfield;
  logic [6:0]  year;
  logic [8:0]  offs;
  logic        adj;
  logic [15:0] yr_days;
  logic [15:0] days_next;
  logic [16:0] tsec_next;

  logic [15:0] days_s1;
  logic [16:0] tsec_s1;
  logic [32:0] dsec_s2;
  logic [16:0] tsec_s2;
  logic [32:0] secs_s3;
  logic [32:0] secs_s4;
  logic [32:0] secs_s5;
  logic [32:0] secs_s6;

  // field split, day count and seconds within the day
  always_comb begin
    sec2    = dos_time[4:0];
    minute  = dos_time[10:5];
    hour    = dos_time[15:11];
    day     = dos_date[4:0];
    mfield  = dos_date[8:5];
    year    = dos_date[15:9];
    // month zero wraps to an unused table code, which reads as zero
    offs    = cum_days(mfield - 4'd1);
    adj     = (year[1:0] == 2'b00) && (mfield <= MONTH_FEB);
    yr_days = 16'(year) * 16'(DAYS_PER_YEAR);
    days_next = 16'(day) + 16'(offs) + 16'(year[6:2]) + yr_days
              + DAYS_1970_TO_1980 - 16'(adj);
    tsec_next = 17'({sec2, 1'b0}) + 17'(minute) * 17'(SECS_PER_MIN)
              + 17'(hour) * 17'(SECS_PER_HOUR);
  end

  // stages: days, days in seconds, total, then delay to match the other path
  always_ff @(posedge clk) begin
    if (en) begin
      days_s1 <= days_next;
      tsec_s1 <= tsec_next;
      dsec_s2 <= 33'(days_s1) * 33'(SECS_PER_DAY);
      tsec_s2 <= tsec_s1;
      secs_s3 <= dsec_s2 + 33'(tsec_s2);
      secs_s4 <= secs_s3;
      secs_s5 <= secs_s4;
      secs_s6 <= secs_s5;
    end
  end

  assign seconds = secs_s6;

endmodule

// ===== src/fdt_u2d.sv =====
`timescale 1ns / 1ps
// fdt_u2d: unix seconds to packed dos time/date pair, six register stages
// depends on fdt_pkg; time and date leave combinationally from the last stage

module fdt_u2d (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] unix_seconds,
  output logic [15:0] time_out,
  output logic [15:0] date_out
);
  import fdt_pkg::*;

  // stage 1: clamp and day reciprocal product
  logic [31:0] uc_next;
  logic [50:0] pd_next;
  logic [31:0] uc_s1;
  logic [50:0] pd_s1;

  always_comb begin
    uc_next = (unix_seconds < SECS_1980) ? SECS_1980 : unix_seconds;
    pd_next = 51'(uc_next[31:7]) * 51'(DAY_RECIP);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uc_s1 <= uc_next;
      pd_s1 <= pd_next;
    end
  end

  // stage 2: day number and seconds of the day
  logic [15:0] qd;
  logic [32:0] qsec;
  logic [32:0] sod_full;
  logic [16:0] sod_s2;
  logic [15:0] dayn_s2;

  always_comb begin
    qd       = pd_s1[50:35];
    qsec     = 33'(qd) * 33'(SECS_PER_DAY);
    sod_full = 33'(uc_s1) - qsec;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sod_s2  <= sod_full[16:0];
      dayn_s2 <= qd - DAYS_1970_TO_1980;
    end
  end

  // stage 3: hour and year reciprocal products
  logic [27:0] ph_s3;
  logic [31:0] py_s3;
  logic [16:0] sod_s3;
  logic [15:0] dayn_s3;

  always_ff @(posedge clk) begin
    if (en) begin
      ph_s3   <= 28'(sod_s2[16:4]) * 28'(HOUR_RECIP);
      py_s3   <= 32'(dayn_s2) * 32'(YEAR_RECIP);
      sod_s3  <= sod_s2;
      dayn_s3 <= dayn_s2;
    end
  end

  // stage 4: hour, seconds of the hour, year estimate and its start days
  logic [4:0]  hr;
  logic [16:0] hsec;
  logic [16:0] remh_full;
  logic [6:0]  y0;
  logic [6:0]  ym1;
  logic [7:0]  y0p3;
  logic [7:0]  ym1p3;
  logic [15:0] b0_next;
  logic [15:0] b1_next;

  logic [4:0]  hr_s4;
  logic [11:0] remh_s4;
  logic [6:0]  y0_s4;
  logic [15:0] b0_s4;
  logic [15:0] b1_s4;
  logic [15:0] dayn_s4;

  always_comb begin
    hr        = ph_s3[26:22];
    hsec      = 17'(hr) * 17'(SECS_PER_HOUR);
    remh_full = sod_s3 - hsec;
    y0        = py_s3[30:24];
    ym1       = y0 - 7'd1;
    y0p3      = 8'(y0) + 8'd3;
    ym1p3     = 8'(ym1) + 8'd3;
    // leap days before a year count (year + 3) / 4
    b0_next   = 16'(y0p3[7:2]) + 16'(y0) * 16'(DAYS_PER_YEAR);
    b1_next   = 16'(ym1p3[7:2]) + 16'(ym1) * 16'(DAYS_PER_YEAR);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hr_s4   <= hr;
      remh_s4 <= remh_full[11:0];
      y0_s4   <= y0;
      b0_s4   <= b0_next;
      b1_s4   <= b1_next;
      dayn_s4 <= dayn_s3;
    end
  end

  // stage 5: minute product, year correction and day of the year
  logic        past;
  logic [15:0] base;
  logic [15:0] doy_full;

  logic [4:0]  hr_s5;
  logic [11:0] remh_s5;
  logic [20:0] pm_s5;
  logic [6:0]  yr_s5;
  logic [8:0]  doy_s5;

  always_comb begin
    past     = b0_s4 > dayn_s4;
    base     = past ? b1_s4 : b0_s4;
    doy_full = dayn_s4 - base;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hr_s5   <= hr_s4;
      remh_s5 <= remh_s4;
      pm_s5   <= 21'(remh_s4[11:2]) * 21'(MIN_RECIP);
      yr_s5   <= past ? (y0_s4 - 7'd1) : y0_s4;
      doy_s5  <= (dayn_s4 >= base) ? doy_full[8:0] : '0;
    end
  end

  // stage 6: minute, second, leap fold and month search
  logic [5:0]  mn;
  logic [11:0] msec;
  logic [11:0] sec_full;
  logic        leap;
  logic [8:0]  nl_next;
  logic [3:0]  mon_next;

  logic [4:0]  hr_s6;
  logic [5:0]  mn_s6;
  logic [5:0]  sec_s6;
  logic [6:0]  yr_s6;
  logic [8:0]  nl_s6;
  logic [3:0]  mon_s6;

  always_comb begin
    mn       = pm_s5[19:14];
    msec     = 12'(mn) * 12'(SECS_PER_MIN);
    sec_full = remh_s5 - msec;
    leap     = (yr_s5[1:0] == 2'b00);
    nl_next  = (!leap || doy_s5 <= DOY_FEB29) ? doy_s5 : (doy_s5 - 9'd1);
    // month of the folded day: the one before the first month whose start lies beyond it
    mon_next = MONTH_DEC;
    for (int m = 11; m >= 1; m--) begin
      if (cum_days(4'(m)) > nl_next) begin
        mon_next = 4'(m);
      end
    end
    // feb 29 of a leap year
    if (leap && doy_s5 == DOY_FEB29) begin
      mon_next = MONTH_FEB;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hr_s6  <= hr_s5;
      mn_s6  <= mn;
      sec_s6 <= sec_full[5:0];
      yr_s6  <= yr_s5;
      nl_s6  <= nl_next;
      mon_s6 <= mon_next;
    end
  end

  // packing
  logic [8:0] cm;

  always_comb begin
    cm       = cum_days(mon_s6 - 4'd1);
    time_out = {hr_s6, mn_s6, sec_s6[5:1]};
    date_out = 16'(nl_s6) - 16'(cm) + 16'd1 + 16'({mon_s6, 5'b0})
             + {yr_s6, 9'b0};
  end

endmodule
